// File: hdl/nts_pkg.sv
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types, format codes and character helpers for the number text
// parse and format block.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int VAL_W = 32;

    // Render format codes
    localparam logic [1:0] FMT_BIN      = 2'd0;
    localparam logic [1:0] FMT_SDEC     = 2'd1;
    localparam logic [1:0] FMT_HEX      = 2'd2;
    localparam logic [1:0] FMT_SWAP_DEC = 2'd3;

    // Request kinds
    localparam logic REQ_PARSE  = 1'b0;
    localparam logic REQ_RENDER = 1'b1;

    // ASCII codes used in more than one place
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NEWLINE = 8'h0a;

    // Input item
    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
        logic       first_char;
        logic [1:0] format_sel;
    } t_nts_in;

    // Result item
    typedef struct packed {
        logic [7:0] char_out;
        logic       line_last;
    } t_nts_out;

    // Parsed value handed from the parser to the renderer
    typedef struct packed {
        logic [VAL_W-1:0] magnitude;
        logic             minus_seen;
    } t_nts_value;

    // Lowercase hex character of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = 8'h61 + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: hdl/nts_parse.sv
// ----------------------------------------------------------------------------
// nts_parse
// Character parser: takes one ASCII character a cycle while i_take is set,
// building a 32-bit magnitude in decimal or hex; tracks a leading minus sign.
// ----------------------------------------------------------------------------
module nts_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_take,
    input  logic [7:0]         i_char,
    input  logic               i_first,
    output nts_pkg::t_nts_value o_value
);
    import nts_pkg::*;

    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_HEX  = 2'd1;
    localparam logic [1:0] MODE_STOP = 2'd2;

    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    logic [VAL_W-1:0] r_mag, n_mag;
    logic             r_minus, n_minus;
    logic [1:0]       r_mode, n_mode;
    logic [1:0]       r_pos, n_pos;

    // Digit decode of the incoming character
    logic             dec_ok, hex_ok;
    logic [3:0]       dec_val, hex_val;

    always_comb begin
        dec_ok  = (i_char >= 8'h30) && (i_char <= 8'h39);
        dec_val = i_char[3:0];
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (dec_ok) begin
            hex_val = i_char[3:0];
        end else if (((i_char >= 8'h61) && (i_char <= 8'h66)) ||
                     ((i_char >= 8'h41) && (i_char <= 8'h46))) begin
            hex_val = i_char[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    // Next parser state: first_char restarts from the reset state
    always_comb begin
        logic [VAL_W-1:0] b_mag;
        logic             b_minus;
        logic [1:0]       b_mode;
        logic [1:0]       b_pos;
        b_mag   = i_first ? '0 : r_mag;
        b_minus = i_first ? 1'b0 : r_minus;
        b_mode  = i_first ? MODE_DEC : r_mode;
        b_pos   = i_first ? 2'd0 : r_pos;

        n_mag   = b_mag;
        n_minus = b_minus;
        n_mode  = b_mode;
        n_pos   = (b_pos == 2'd3) ? b_pos : b_pos + 2'd1;

        if ((b_mode == MODE_DEC) || (b_mode == MODE_HEX)) begin
            if ((b_pos == 2'd0) && (i_char == CH_MINUS)) begin
                n_minus = 1'b1;
            end else if ((b_pos == 2'd1) && (i_char == CH_X) && (b_mode == MODE_DEC) &&
                         !b_minus && (b_mag == '0)) begin
                n_mode = MODE_HEX;
            end else if (b_mode == MODE_HEX) begin
                if (hex_ok) begin
                    n_mag = {b_mag[VAL_W-5:0], hex_val};
                end else begin
                    n_mode = MODE_STOP;
                end
            end else begin
                // times ten is (x << 3) + (x << 1)
                if (dec_ok) begin
                    n_mag = {b_mag[VAL_W-4:0], 3'd0} + {b_mag[VAL_W-2:0], 1'b0} +
                            {{(VAL_W-4){1'b0}}, dec_val};
                end else begin
                    n_mode = MODE_STOP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag   <= '0;
            r_minus <= 1'b0;
            r_mode  <= MODE_DEC;
            r_pos   <= 2'd0;
        end else if (i_take) begin
            r_mag   <= n_mag;
            r_minus <= n_minus;
            r_mode  <= n_mode;
            r_pos   <= n_pos;
        end
    end

    assign o_value.magnitude  = r_mag;
    assign o_value.minus_seen = r_minus;

endmodule

// File: hdl/nts_render.sv
// ----------------------------------------------------------------------------
// nts_render
// Line renderer: shifts the value out one bit or one digit a cycle while the
// output is not stalled, converts to decimal with a serial shift-add-3 pass,
// and drives the result register.
// ----------------------------------------------------------------------------
module nts_render (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_fmt,
    input  nts_pkg::t_nts_value i_value,
    output logic                o_busy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nts_pkg::t_nts_out   o_out_data
);
    import nts_pkg::*;

    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int CNT_W      = 6;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PFX0 = 4'd1;
    localparam logic [3:0] ST_PFX1 = 4'd2;
    localparam logic [3:0] ST_DIGB = 4'd3;
    localparam logic [3:0] ST_DIGH = 4'd4;
    localparam logic [3:0] ST_SIGN = 4'd5;
    localparam logic [3:0] ST_CONV = 4'd6;
    localparam logic [3:0] ST_DIGD = 4'd7;
    localparam logic [3:0] ST_NL   = 4'd8;

    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_fmt, n_fmt;
    logic [VAL_W-1:0] r_val, n_val;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_started, n_started;

    logic             r_ovalid;
    logic [7:0]       r_ochar;
    logic             r_olast;

    logic             can_load;
    logic             emit;
    logic [7:0]       e_char;
    logic             e_last;
    logic             is_last;

    logic [VAL_W-1:0] neg_mag, value, swapped;
    logic [BCD_W-1:0] bcd_adj;

    assign can_load = !r_ovalid || i_out_ready;
    assign is_last  = (r_cnt == CNT_W'(1));

    // Signed value and its byte-swapped form
    assign neg_mag = '0 - i_value.magnitude;
    assign value   = i_value.minus_seen ? neg_mag : i_value.magnitude;
    assign swapped = {value[7:0], value[15:8], value[23:16], value[31:24]};

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                          : r_bcd[4*i +: 4];
        end
    end

    // Sequencer
    always_comb begin
        logic show;
        show      = 1'b0;
        n_state   = r_state;
        n_fmt     = r_fmt;
        n_val     = r_val;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_started = r_started;
        emit      = 1'b0;
        e_char    = CH_ZERO;
        e_last    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_fmt = i_fmt;
                    n_bcd = '0;
                    n_cnt = CNT_W'(VAL_W);
                    unique case (i_fmt)
                        FMT_BIN: begin
                            n_val   = value;
                            n_state = ST_PFX0;
                        end
                        FMT_HEX: begin
                            n_val   = value;
                            n_cnt   = CNT_W'(VAL_W / 4);
                            n_state = ST_PFX0;
                        end
                        FMT_SDEC: begin
                            // |value| is either the magnitude or its negation
                            n_val   = (i_value.minus_seen ^ value[VAL_W-1]) ? neg_mag
                                                                           : i_value.magnitude;
                            n_state = value[VAL_W-1] ? ST_SIGN : ST_CONV;
                        end
                        default: begin
                            n_val   = swapped;
                            n_state = ST_CONV;
                        end
                    endcase
                end
            end
            ST_PFX0: begin
                emit   = 1'b1;
                e_char = CH_ZERO;
                if (can_load) begin
                    n_state = ST_PFX1;
                end
            end
            ST_PFX1: begin
                emit   = 1'b1;
                e_char = (r_fmt == FMT_BIN) ? CH_B : CH_X;
                if (can_load) begin
                    n_started = 1'b0;
                    n_state   = (r_fmt == FMT_BIN) ? ST_DIGB : ST_DIGH;
                end
            end
            ST_DIGB: begin
                show   = r_val[VAL_W-1] || r_started || is_last;
                emit   = show;
                e_char = r_val[VAL_W-1] ? CH_ONE : CH_ZERO;
                if (!show || can_load) begin
                    n_val     = {r_val[VAL_W-2:0], 1'b0};
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_started = r_started || show;
                    if (is_last) begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_DIGH: begin
                show   = (r_val[VAL_W-1 -: 4] != 4'd0) || r_started || is_last;
                emit   = show;
                e_char = hex_char(r_val[VAL_W-1 -: 4]);
                if (!show || can_load) begin
                    n_val     = {r_val[VAL_W-5:0], 4'd0};
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_started = r_started || show;
                    if (is_last) begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_SIGN: begin
                emit   = 1'b1;
                e_char = CH_MINUS;
                if (can_load) begin
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                // one binary bit enters the BCD register per cycle
                n_bcd = {bcd_adj[BCD_W-2:0], r_val[VAL_W-1]};
                n_val = {r_val[VAL_W-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (is_last) begin
                    n_cnt     = CNT_W'(BCD_DIGITS);
                    n_started = 1'b0;
                    n_state   = ST_DIGD;
                end
            end
            ST_DIGD: begin
                show   = (r_bcd[BCD_W-1 -: 4] != 4'd0) || r_started || is_last;
                emit   = show;
                e_char = CH_ZERO + {4'd0, r_bcd[BCD_W-1 -: 4]};
                if (!show || can_load) begin
                    n_bcd     = {r_bcd[BCD_W-5:0], 4'd0};
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_started = r_started || show;
                    if (is_last) begin
                        n_state = ST_NL;
                    end
                end
            end
            ST_NL: begin
                emit   = 1'b1;
                e_char = CH_NEWLINE;
                e_last = 1'b1;
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_started <= 1'b0;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_cnt     <= n_cnt;
            if (emit && can_load) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Data registers
    always_ff @(posedge i_clk) begin
        r_fmt <= n_fmt;
        r_val <= n_val;
        r_bcd <= n_bcd;
        if (emit && can_load) begin
            r_ochar <= e_char;
            r_olast <= e_last;
        end
    end

    assign o_busy               = (r_state != ST_IDLE);
    assign o_out_valid          = r_ovalid;
    assign o_out_data.char_out  = r_ochar;
    assign o_out_data.line_last = r_olast;

endmodule

// File: hdl/number_text_parse_and_format.sv
// ----------------------------------------------------------------------------
// number_text_parse_and_format
// ASCII number parser with a serial line renderer (binary, signed decimal,
// hex, byte-swapped unsigned decimal).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) carries one item per
//   handshake. A parse item updates the parser registers and gives no
//   result; parse items can be taken back to back, one per cycle.
//   A render item starts the line renderer, which sends one character per
//   handshake on the output channel (o_out_valid / i_out_ready / o_out_data),
//   the newline flagged with line_last. No new item is taken until the last
//   character has entered the output register.
//   A render item steps in order: binary sends 0b, then the bits; hex sends
//   0x, then the nibbles; decimal sends any minus sign, runs the serial
//   shift-add-3 conversion and then sends the digits. The newline ends a line.
//   Leading zero bits or digits, but the last, are shifted past and send nothing.
//   Output stalls hold the renderer on the pending character.
//   Reset clears the parser to zero in decimal mode and empties the output.
// ----------------------------------------------------------------------------
module number_text_parse_and_format (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  nts_pkg::t_nts_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output nts_pkg::t_nts_out o_out_data
);
    import nts_pkg::*;

    logic       busy;
    logic       take;
    logic       take_parse;
    logic       take_render;
    t_nts_value value;

    assign o_in_ready  = !busy;
    assign take        = i_in_valid && !busy;
    assign take_parse  = take && (i_in_data.req_type == REQ_PARSE);
    assign take_render = take && (i_in_data.req_type == REQ_RENDER);

    // Parser state
    nts_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take_parse),
        .i_char  (i_in_data.char_in),
        .i_first (i_in_data.first_char),
        .o_value (value)
    );

    // Line renderer and output register
    nts_render u_render (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (take_render),
        .i_fmt       (i_in_data.format_sel),
        .i_value     (value),
        .o_busy      (busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: verif/number_text_parse_and_format_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// number_text_parse_and_format_tb
// Drives parse and render items into the block with random idle gaps and
// output stalls. A scoreboard tracks the parser value and builds the
// expected characters of every rendered line, which are checked in order.
// ----------------------------------------------------------------------------
module number_text_parse_and_format_tb;

    import nts_pkg::*;

    localparam int          STUCK_LIMIT = 4000;
    localparam int          PRINT_MAX   = 20;
    localparam logic [7:0]  CH_MINUS    = "-";
    localparam logic [7:0]  CH_LOWER_X  = "x";
    localparam logic [7:0]  CH_LOWER_B  = "b";
    localparam string       DIGIT_CHARS = "0123456789abcdef";
    localparam string       HEX_INPUTS  = "0123456789abcdefABCDEF";

    typedef enum logic [1:0] {
        SCAN_DEC  = 2'd0,
        SCAN_HEX  = 2'd1,
        SCAN_STOP = 2'd2
    } t_scan_mode;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_nts_in    in_data  = '0;
    logic       out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_nts_out   o_out_data;

    // Scoreboard copy of the parser state
    logic [31:0] num_mag   = '0;
    logic        num_neg   = 1'b0;
    t_scan_mode  scan_mode = SCAN_DEC;
    logic [1:0]  scan_pos  = 2'd0;

    t_nts_out    line_chars_due[$];
    int          fail_count    = 0;
    int          chars_checked = 0;
    int          items_sent    = 0;
    int          stuck_cycles  = 0;
    bit          gaps_on       = 1'b1;
    bit          stalls_on     = 1'b1;
    int          rx_hold_req   = 0;

    number_text_parse_and_format u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Scoreboard model
    // ------------------------------------------------------------------------
    function automatic void clear_scan();
        num_mag   = '0;
        num_neg   = 1'b0;
        scan_mode = SCAN_DEC;
        scan_pos  = 2'd0;
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic [1:0] pos;
        logic [3:0] nib;
        pos = scan_pos;
        if (scan_pos != 2'd3) begin
            scan_pos = scan_pos + 2'd1;
        end
        if (scan_mode != SCAN_DEC && scan_mode != SCAN_HEX) begin
            return;
        end
        // leading minus
        if (pos == 2'd0 && c == CH_MINUS) begin
            num_neg = 1'b1;
            return;
        end
        // "0x" prefix
        if (pos == 2'd1 && c == CH_LOWER_X && scan_mode == SCAN_DEC &&
            !num_neg && num_mag == '0) begin
            scan_mode = SCAN_HEX;
            return;
        end
        if (scan_mode == SCAN_HEX) begin
            if (c >= "0" && c <= "9") begin
                nib = c[3:0];
            end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
                nib = c[3:0] + 4'd9;
            end else begin
                scan_mode = SCAN_STOP;
                return;
            end
            num_mag = {num_mag[27:0], nib};
        end else begin
            if (c >= "0" && c <= "9") begin
                num_mag = num_mag * 32'd10 + {28'd0, c[3:0]};
            end else begin
                scan_mode = SCAN_STOP;
            end
        end
    endfunction

    function automatic void due_char(logic [7:0] ch, logic last);
        t_nts_out e;
        e.char_out  = ch;
        e.line_last = last;
        line_chars_due.push_back(e);
    endfunction

    function automatic void due_udec(logic [31:0] x);
        logic [7:0] digits[$];
        if (x == '0) begin
            due_char(CH_ZERO, 1'b0);
            return;
        end
        while (x != '0) begin
            digits.push_front(CH_ZERO + 8'(x % 32'd10));
            x = x / 32'd10;
        end
        foreach (digits[i]) begin
            due_char(digits[i], 1'b0);
        end
    endfunction

    function automatic void render_line(logic [1:0] fmt);
        logic [31:0] v;
        logic [3:0]  nib;
        bit          started;
        v = num_neg ? (32'd0 - num_mag) : num_mag;
        started = 1'b0;
        case (fmt)
            FMT_BIN: begin
                due_char(CH_ZERO, 1'b0);
                due_char(CH_LOWER_B, 1'b0);
                for (int s = 31; s >= 0; s--) begin
                    if (v[s] || started || s == 0) begin
                        due_char(v[s] ? "1" : "0", 1'b0);
                        started = 1'b1;
                    end
                end
            end
            FMT_SDEC: begin
                if (v[31]) begin
                    due_char(CH_MINUS, 1'b0);
                    due_udec(32'd0 - v);
                end else begin
                    due_udec(v);
                end
            end
            FMT_HEX: begin
                due_char(CH_ZERO, 1'b0);
                due_char(CH_LOWER_X, 1'b0);
                for (int s = 7; s >= 0; s--) begin
                    nib = v[s*4 +: 4];
                    if (nib != 4'd0 || started || s == 0) begin
                        due_char(DIGIT_CHARS[nib], 1'b0);
                        started = 1'b1;
                    end
                end
            end
            default: begin
                due_udec({v[7:0], v[15:8], v[23:16], v[31:24]});
            end
        endcase
        due_char(CH_NEWLINE, 1'b1);
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    // valid stays high after acceptance so the next item can follow at once;
    // anything that pauses the stream lowers it first
    task automatic send_item(t_nts_in item);
        int gap;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (item.req_type == REQ_PARSE) begin
            if (item.first_char) begin
                clear_scan();
            end
            scan_char(item.char_in);
        end else begin
            render_line(item.format_sel);
        end
    endtask

    task automatic send_parse(logic [7:0] c, logic first);
        t_nts_in item;
        item.req_type   = REQ_PARSE;
        item.char_in    = c;
        item.first_char = first;
        item.format_sel = 2'($urandom_range(0, 3));
        send_item(item);
    endtask

    task automatic send_render(logic [1:0] fmt);
        t_nts_in item;
        item.req_type   = REQ_RENDER;
        item.char_in    = 8'($urandom_range(0, 255));
        item.first_char = 1'($urandom_range(0, 1));
        item.format_sel = fmt;
        send_item(item);
    endtask

    task automatic send_text(string s);
        foreach (s[i]) begin
            send_parse(s[i], i == 0);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (line_chars_due.size() != 0) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall per character, long hold on request
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : rx_stall
        int wait_left;
        if (out_ready && o_out_valid) begin
            wait_left = stalls_on ? $urandom_range(0, 11) : 0;
        end
        if (rx_hold_req > 0) begin
            wait_left   = rx_hold_req;
            rx_hold_req = 0;
        end
        if (wait_left > 0) begin
            out_ready <= 1'b0;
            wait_left--;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result check and watchdog
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < PRINT_MAX) begin
            $display("%0t: %s mismatch at char %0d: got %0d, expected %0d",
                     $realtime, what, chars_checked, got, want);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_nts_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (line_chars_due.size() == 0) begin
                report_mismatch("unexpected char", o_out_data.char_out, 0);
            end else begin
                want = line_chars_due.pop_front();
                if (o_out_data.char_out !== want.char_out) begin
                    report_mismatch("char_out", o_out_data.char_out, want.char_out);
                end
                if (o_out_data.line_last !== want.line_last) begin
                    report_mismatch("line_last", o_out_data.line_last, want.line_last);
                end
            end
            chars_checked++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
            $display("FAIL number_text_parse_and_format");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // zero after reset, and characters with no first_char since reset
    task automatic test_reset_defaults();
        send_render(FMT_BIN);
        send_parse("7", 1'b0);
        send_render(FMT_SDEC);
        wait_drained();
    endtask

    // lone minus, bare hex prefix, misplaced x with chars after the stop
    task automatic test_sign_and_prefix();
        send_text("-");
        send_render(FMT_SDEC);
        send_text("0x");
        send_render(FMT_HEX);
        send_text("1x5");
        send_render(FMT_SWAP_DEC);
        wait_drained();
    endtask

    // most negative value in every format
    task automatic test_extreme_values();
        send_text("0x80000000");
        send_render(FMT_SDEC);
        send_render(FMT_BIN);
        send_render(FMT_HEX);
        send_render(FMT_SWAP_DEC);
        wait_drained();
    endtask

    // receiver holds off while renders keep coming, so the input stalls
    task automatic test_backpressure();
        gaps_on     = 1'b0;
        rx_hold_req = 300;
        send_text("1234567");
        send_render(FMT_BIN);
        send_render(FMT_SDEC);
        send_render(FMT_HEX);
        send_render(FMT_SWAP_DEC);
        wait_drained();
        gaps_on = 1'b1;
    endtask

    // one number text, mostly well formed, then one or two renders
    task automatic send_random_number();
        int kind;
        int n;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                n = $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    send_parse(8'("0" + $urandom_range(0, 9)), i == 0);
                end
            end
            3, 4: begin
                send_parse(CH_MINUS, 1'b1);
                n = $urandom_range(0, 11);
                for (int i = 0; i < n; i++) begin
                    send_parse(8'("0" + $urandom_range(0, 9)), 1'b0);
                end
            end
            5, 6, 7: begin
                send_parse(CH_ZERO, 1'b1);
                send_parse(CH_LOWER_X, 1'b0);
                n = $urandom_range(0, 9);
                for (int i = 0; i < n; i++) begin
                    send_parse(HEX_INPUTS[$urandom_range(0, 21)], 1'b0);
                end
            end
            8: begin
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    send_parse(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
            end
            default: begin
                // digits broken by a stray char, then one more digit
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    send_parse(8'("0" + $urandom_range(0, 9)), i == 0);
                end
                send_parse(8'($urandom_range(0, 255)), 1'b0);
                send_parse(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
        endcase
        if ($urandom_range(0, 3) == 0) begin
            send_parse(8'($urandom_range(0, 255)), 1'b0);
        end
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++) begin
            send_render(2'($urandom_range(0, 3)));
        end
    endtask

    // four phases with every mix of sender gaps and receiver stalls
    task automatic test_random_traffic();
        int stop_at;
        for (int phase = 0; phase < 4; phase++) begin
            gaps_on   = phase[0];
            stalls_on = phase[1];
            stop_at   = items_sent + 120;
            while (items_sent < stop_at) begin
                send_random_number();
            end
            wait_drained();
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_sign_and_prefix();
        test_extreme_values();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS number_text_parse_and_format");
        end else begin
            $display("FAIL number_text_parse_and_format");
        end
        $finish;
    end

endmodule
